// ===== src/bpl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the 3x3 box-sum peak locator.
// Holds field widths, register codes and the structs shared by the modules.
package bpl_pkg;

  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned COLSUM_W   = 10;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } bpl_reg_e;

  // One pixel on its way from the counters to the window stage.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               interior;
    logic               frame_end;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
  } bpl_item_t;

  // One line store entry: the pixels one and two rows above.
  typedef struct packed {
    logic [PIXEL_W-1:0] up1;
    logic [PIXEL_W-1:0] up2;
  } bpl_lines_t;

endpackage

// ===== src/bpl_if.sv =====
`timescale 1ns / 1ps
// Stream interfaces of the peak locator: pixel input and peak result.
// Depends on bpl_pkg for the field widths.
interface bpl_pixel_if;
  import bpl_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bpl_peak_if;
  import bpl_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] peak_col;
  logic [POS_W-1:0] peak_row;
  logic [SUM_W-1:0] peak_sum;
  logic             found;
  modport source (output valid, output peak_col, output peak_row, output peak_sum,
                  output found, input ready);
  modport sink (input valid, input peak_col, input peak_row, input peak_sum,
                input found, output ready);
endinterface

// ===== src/bpl_regs.sv =====
`timescale 1ns / 1ps
// APB configuration registers: frame width and frame height.
// Depends on bpl_pkg.
module bpl_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpl_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bpl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bpl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [bpl_pkg::CFG_W-1:0]       frame_width_o,
  output logic [bpl_pkg::CFG_W-1:0]       frame_height_o
);
  import bpl_pkg::*;

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  bpl_reg_e         reg_sel;
  logic             wr_en;

  assign reg_sel = bpl_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:          prdata = '0;
    endcase
  end

  assign frame_width_o  = width_q;
  assign frame_height_o = height_q;

endmodule

// ===== src/bpl_line_buf.sv =====
`timescale 1ns / 1ps
// Combined line store for the two rows above the current one.
// Synchronous read with write-to-read forwarding; uses bpl_pkg.
module bpl_line_buf #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  bpl_pkg::bpl_lines_t      wr_data_i,
  output bpl_pkg::bpl_lines_t      rd_data_o
);
  import bpl_pkg::*;

  bpl_lines_t mem [DEPTH];
  bpl_lines_t mem_q;
  bpl_lines_t byp_data_q;
  logic       byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_q      <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // A read that meets a write to the same entry takes the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : mem_q;

endmodule

// ===== src/bpl_peak.sv =====
`timescale 1ns / 1ps
// Window stage: column sums, 3x3 box sum, running peak and the result register.
// Depends on bpl_pkg and bpl_peak_if.
module bpl_peak (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  bpl_pkg::bpl_item_t  item_i,
  input  bpl_pkg::bpl_lines_t lines_i,
  bpl_peak_if.source          peak_o
);
  import bpl_pkg::*;

  logic [COLSUM_W-1:0] ws_a_q, ws_b_q;
  logic [SUM_W-1:0]    best_sum_q, best_sum_d;
  logic [POS_W-1:0]    best_col_q, best_col_d;
  logic [POS_W-1:0]    best_row_q, best_row_d;
  logic                best_v_q, best_v_d;
  logic [POS_W-1:0]    out_col_q, out_row_q;
  logic [SUM_W-1:0]    out_sum_q;
  logic                out_found_q;
  logic                out_v_q;
  logic [COLSUM_W-1:0] colsum;
  logic [SUM_W-1:0]    box;
  logic                take;
  logic                fire;

  assign ready_o = !item_i.frame_end || !out_v_q || peak_o.ready;
  assign fire    = valid_i && ready_o;

  always_comb begin
    colsum = COLSUM_W'(lines_i.up2) + COLSUM_W'(lines_i.up1) + COLSUM_W'(item_i.pixel);
    box    = SUM_W'(ws_a_q) + SUM_W'(ws_b_q) + SUM_W'(colsum);
    take   = item_i.interior && (!best_v_q || (box > best_sum_q));
    best_sum_d = best_sum_q;
    best_col_d = best_col_q;
    best_row_d = best_row_q;
    best_v_d   = best_v_q;
    if (take) begin
      best_sum_d = box;
      best_col_d = item_i.col;
      best_row_d = item_i.row;
      best_v_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_a_q      <= '0;
      ws_b_q      <= '0;
      best_sum_q  <= '0;
      best_col_q  <= '0;
      best_row_q  <= '0;
      best_v_q    <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_sum_q   <= '0;
      out_found_q <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      out_v_q <= (out_v_q && !peak_o.ready) || (fire && item_i.frame_end);
      if (fire) begin
        if (item_i.frame_end) begin
          out_col_q   <= best_v_d ? best_col_d : '0;
          out_row_q   <= best_v_d ? best_row_d : '0;
          out_sum_q   <= best_v_d ? best_sum_d : '0;
          out_found_q <= best_v_d;
          ws_a_q      <= '0;
          ws_b_q      <= '0;
          best_sum_q  <= '0;
          best_col_q  <= '0;
          best_row_q  <= '0;
          best_v_q    <= 1'b0;
        end else begin
          ws_a_q     <= ws_b_q;
          ws_b_q     <= colsum;
          best_sum_q <= best_sum_d;
          best_col_q <= best_col_d;
          best_row_q <= best_row_d;
          best_v_q   <= best_v_d;
        end
      end
    end
  end

  assign peak_o.valid    = out_v_q;
  assign peak_o.peak_col = out_col_q;
  assign peak_o.peak_row = out_row_q;
  assign peak_o.peak_sum = out_sum_q;
  assign peak_o.found    = out_found_q;

endmodule

// ===== src/box3x3_peak_locator.sv =====
`timescale 1ns / 1ps
// Top level of the 3x3 box-sum peak locator: raster counters and pipeline control.
// Depends on bpl_pkg, bpl_if, bpl_regs, bpl_line_buf and bpl_peak.
//
//   Port       Dir   Handshake              Transaction
//   pixel_i    in    valid / ready          one 8-bit pixel in raster order
//   peak_o     out   valid / ready          peak position, sum and found flag per frame
//   APB        in    psel, penable, pready  write or read of frame width or height
//
// One pixel is accepted every cycle unless the input stalls; the line store reads one
// entry when a pixel is accepted and writes it back when that pixel leaves the stage-1
// register. The frame result is registered when the frame's last pixel leaves it.
// The line store is never cleared; reset covers counters, peak state and size registers.
// Input stalls only while a finished result waits and the next frame's last pixel arrives.
module box3x3_peak_locator #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bpl_pixel_if.sink                       pixel_i,
  bpl_peak_if.source                      peak_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpl_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bpl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bpl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import bpl_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int unsigned CHW = (HW > CFG_W) ? HW : CFG_W;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [WW-1:0]    width_eff;
  logic [HW-1:0]    height_eff;
  logic [AW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic             row_end, frame_end;
  logic             accept;
  logic             s1_v_q;
  bpl_item_t        s1_q, item_d;
  logic [AW-1:0]    s1_addr_q;
  logic             s1_ready, s1_fire;
  bpl_lines_t       rd_lines, wr_lines;

  bpl_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .frame_width_o  (frame_width),
    .frame_height_o (frame_height)
  );

  always_comb begin
    if (frame_width == '0) begin
      width_eff = WW'(1);
    end else if (CWW'(frame_width) > CWW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = HW'(1);
    end else if (CHW'(frame_height) > CHW'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(frame_height);
    end
  end

  assign s1_fire       = s1_v_q && s1_ready;
  assign pixel_i.ready = !s1_v_q || s1_ready;
  assign accept        = pixel_i.valid && pixel_i.ready;

  always_comb begin
    row_end   = (WW'(col_q) + WW'(1)) >= width_eff;
    frame_end = row_end && ((HW'(row_q) + HW'(1)) >= height_eff);
    item_d.pixel     = pixel_i.pixel;
    item_d.interior  = (col_q >= AW'(2)) && (row_q >= RW'(2));
    item_d.frame_end = frame_end;
    item_d.col       = POS_W'(col_q) - POS_W'(1);
    item_d.row       = POS_W'(row_q) - POS_W'(1);
    if (frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + RW'(1);
    end else begin
      col_d = col_q + AW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q  <= col_d;
        row_q  <= row_d;
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q      <= item_d;
      s1_addr_q <= col_q;
    end
  end

  assign wr_lines.up1 = s1_q.pixel;
  assign wr_lines.up2 = rd_lines.up1;

  bpl_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_lines),
    .rd_data_o (rd_lines)
  );

  bpl_peak u_peak (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q),
    .ready_o (s1_ready),
    .item_i  (s1_q),
    .lines_i (rd_lines),
    .peak_o  (peak_o)
  );

endmodule

// ===== tb/sv/bpl_checker.sv =====
`timescale 1ns / 1ps
// Checker for the 3x3 box-sum peak locator: predicts each frame's peak and
// compares every result transaction. Depends on bpl_pkg and bpl_if.
module bpl_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bpl_pixel_if                           pix_i,
  bpl_peak_if                            peak_i,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [bpl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bpl_pkg::APB_DATA_W-1:0] pwdata,
  output int unsigned                    fail_o,
  output int unsigned                    pending_o,
  output int unsigned                    peaks_o
);
  import bpl_pkg::*;

  localparam int unsigned MAX_W = 2048;
  localparam int unsigned MAX_H = 2048;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [SUM_W-1:0] sum;
    logic             found;
  } peak_rec_t;

  logic [PIXEL_W-1:0]  row_above      [MAX_W];
  logic [PIXEL_W-1:0]  two_rows_above [MAX_W];
  logic [COLSUM_W-1:0] col_sums       [3];
  int unsigned         col_pos;
  int unsigned         row_pos;
  int unsigned         best_sum;
  int unsigned         best_col;
  int unsigned         best_row;
  logic                best_seen;
  logic [CFG_W-1:0]    width_reg;
  logic [CFG_W-1:0]    height_reg;
  peak_rec_t           expected_peaks [$];
  peak_rec_t           head;
  int unsigned         failures;
  int unsigned         peaks_checked;

  function automatic int unsigned fit_size(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < 3; i++) col_sums[i] = '0;
    col_pos   = 0;
    row_pos   = 0;
    best_sum  = 0;
    best_col  = 0;
    best_row  = 0;
    best_seen = 1'b0;
  endtask

  task automatic predict_pixel(input logic [PIXEL_W-1:0] p);
    int unsigned         w;
    int unsigned         h;
    int unsigned         box;
    logic [PIXEL_W-1:0]  up1;
    logic [PIXEL_W-1:0]  up2;
    logic                row_end;
    logic                frame_end;
    peak_rec_t           rec;
    w   = fit_size(width_reg, MAX_W);
    h   = fit_size(height_reg, MAX_H);
    up1 = '0;
    up2 = '0;
    if (col_pos < MAX_W) begin
      up1 = row_above[col_pos];
      up2 = two_rows_above[col_pos];
      two_rows_above[col_pos] = up1;
      row_above[col_pos]      = p;
    end
    col_sums[0] = col_sums[1];
    col_sums[1] = col_sums[2];
    col_sums[2] = COLSUM_W'(up1) + COLSUM_W'(up2) + COLSUM_W'(p);
    if (col_pos >= 2 && row_pos >= 2) begin
      box = int'(col_sums[0]) + int'(col_sums[1]) + int'(col_sums[2]);
      if (!best_seen || box > best_sum) begin
        best_sum  = box;
        best_col  = col_pos - 1;
        best_row  = row_pos - 1;
        best_seen = 1'b1;
      end
    end
    row_end   = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    if (frame_end) begin
      rec.col   = best_seen ? POS_W'(best_col) : '0;
      rec.row   = best_seen ? POS_W'(best_row) : '0;
      rec.sum   = best_seen ? SUM_W'(best_sum) : '0;
      rec.found = best_seen;
      expected_peaks.push_back(rec);
      clear_frame();
    end else if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_W; i++) begin
        row_above[i]      = '0;
        two_rows_above[i] = '0;
      end
      clear_frame();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      expected_peaks.delete();
      failures      = 0;
      peaks_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (bpl_reg_e'(paddr[2]))
          REG_FRAME_WIDTH: begin
            width_reg = pwdata[CFG_W-1:0];
          end
          REG_FRAME_HEIGHT: begin
            height_reg = pwdata[CFG_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        predict_pixel(pix_i.pixel);
      end
      if (peak_i.valid && peak_i.ready) begin
        if (expected_peaks.size() == 0) begin
          $error("peak result arrived with no frame pending");
          failures++;
        end else begin
          head = expected_peaks.pop_front();
          check_field("peak_col", 32'(head.col), 32'(peak_i.peak_col));
          check_field("peak_row", 32'(head.row), 32'(peak_i.peak_row));
          check_field("peak_sum", 32'(head.sum), 32'(peak_i.peak_sum));
          check_field("found", 32'(head.found), 32'(peak_i.found));
          peaks_checked++;
        end
      end
    end
    fail_o    <= failures;
    pending_o <= expected_peaks.size();
    peaks_o   <= peaks_checked;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the peak locator testbench: clock, reset, frame stimulus, register
// writes and the verdict. Depends on bpl_pkg, bpl_if, bpl_checker and the block.
module testbench;
  import bpl_pkg::*;

  typedef enum int {
    PAT_RANDOM,
    PAT_ZERO,
    PAT_FULL,
    PAT_BINARY,
    PAT_SPOT
  } pattern_e;

  localparam int unsigned HOLD_CYCLES = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           peaks_seen;
  int unsigned           tx_idle_pct = 10;
  int unsigned           rx_idle_pct = 87;
  int unsigned           frames_sent = 0;
  int unsigned           pixels_sent = 0;
  logic [CFG_W-1:0]      cur_w = FRAME_WIDTH_RST;
  logic [CFG_W-1:0]      cur_h = FRAME_HEIGHT_RST;
  logic                  hold_request = 1'b0;
  logic                  hold_done = 1'b0;

  bpl_pixel_if pix_if ();
  bpl_peak_if  peak_if ();

  box3x3_peak_locator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pix_if),
    .peak_o  (peak_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bpl_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_if),
    .peak_i    (peak_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_o    (fail_count),
    .pending_o (pending),
    .peaks_o   (peaks_seen)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic apb_write(input bpl_reg_e r, input logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= p;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic run_frame(input logic [CFG_W-1:0] w_set, input logic [CFG_W-1:0] h_set,
                           input pattern_e pat);
    int unsigned w;
    int unsigned h;
    int unsigned spot;
    logic [PIXEL_W-1:0] p;
    if (w_set != cur_w || h_set != cur_h) begin
      drain();
      if (w_set != cur_w) apb_write(REG_FRAME_WIDTH, w_set);
      if (h_set != cur_h) apb_write(REG_FRAME_HEIGHT, h_set);
      cur_w = w_set;
      cur_h = h_set;
    end
    w    = (w_set == 0) ? 1 : ((w_set > 2048) ? 2048 : w_set);
    h    = (h_set == 0) ? 1 : ((h_set > 2048) ? 2048 : h_set);
    spot = $urandom_range(w * h - 1);
    for (int i = 0; i < w * h; i++) begin
      case (pat)
        PAT_ZERO:   p = '0;
        PAT_FULL:   p = '1;
        PAT_BINARY: p = $urandom_range(1) ? 8'hFF : 8'h00;
        PAT_SPOT:   p = (i == spot) ? 8'hFF : PIXEL_W'($urandom_range(20));
        default:    p = PIXEL_W'($urandom_range(255));
      endcase
      send_pixel(p);
    end
    frames_sent++;
  endtask

  task automatic random_frames(input int unsigned n);
    int unsigned w;
    int unsigned h;
    w = 5;
    h = 5;
    repeat (n) begin
      if ($urandom_range(2) != 0) begin
        if ($urandom_range(9) == 0) begin
          w = $urandom_range(40, 10);
          h = $urandom_range(5, 3);
        end else begin
          w = $urandom_range(9, 1);
          h = $urandom_range(9, 1);
        end
      end
      run_frame(CFG_W'(w), CFG_W'(h), pattern_e'($urandom_range(4)));
    end
  endtask

  initial begin
    peak_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        peak_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        peak_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_frame(1, 1, PAT_RANDOM);
    run_frame(2, 2, PAT_FULL);
    run_frame(1, 5, PAT_RANDOM);
    run_frame(5, 1, PAT_RANDOM);
    run_frame(3, 2, PAT_FULL);
    run_frame(2, 3, PAT_FULL);
    run_frame(3, 3, PAT_ZERO);
    run_frame(3, 3, PAT_FULL);
    run_frame(4, 4, PAT_BINARY);
    run_frame(5, 4, PAT_SPOT);
    run_frame(7, 6, PAT_ZERO);
    run_frame(0, 0, PAT_RANDOM);
    run_frame(0, 3, PAT_RANDOM);
    random_frames(3);

    tx_idle_pct = 87;
    rx_idle_pct = 10;
    random_frames(3);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_frame(3, 3, PAT_RANDOM);
    hold_request = 1'b1;
    repeat (4) run_frame(3, 3, PAT_RANDOM);
    random_frames(2);

    drain();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d frames (%0d pixels) and checked %0d peak results,", frames_sent,
             pixels_sent, peaks_seen);
    $display("covering tiny and zero-size frames, three idle profiles and a long stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
